// ----- rtl/core/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher package
// Shared constants, the key square type and the cell-search and wrap helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

    // Square geometry and field widths
    localparam int SIDE    = 5;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = SIDE * CHAR_W;
    localparam int POS_W   = $clog2(SIDE);
    localparam int ADDR_W  = $clog2(SIDE);

    // Request codes
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_MISSING = 1'b1;

    // Key square: row-major, column 0 in the low byte of each row
    typedef logic [SIDE-1:0][SIDE-1:0][CHAR_W-1:0] square_t;

    // Position of a letter in the square
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } cell_pos_t;

    // Compare a code against every cell; the latest match in row-major order wins
    function automatic cell_pos_t locate(input square_t sq, input logic [CHAR_W-1:0] code);
        cell_pos_t res;
        res = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (sq[r][c] == code) begin
                    res.found = 1'b1;
                    res.row   = POS_W'(r);
                    res.col   = POS_W'(c);
                end
            end
        end
        return res;
    endfunction

    // Move one place forward or back with wrap round the square side
    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] v,
                                                   input logic backward);
        logic [POS_W-1:0] res;
        if (backward) begin
            res = (v == '0) ? POS_W'(SIDE - 1) : v - POS_W'(1);
        end
        else begin
            res = (v == POS_W'(SIDE - 1)) ? '0 : v + POS_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/playfair_digraph_cipher_core.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher core
// Encrypts or decrypts one letter pair against a 5x5 key square held in
// five row registers written through a plain configuration port.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, with the 25-cell search and
//   cell select between them.
// Throughput: one pair per cycle while the output is not stalled; the result
//   register frees the input side while a finished item waits for out_ready.
// Reset: asynchronous, active low; clears both stage valids and the square.
`default_nettype none

module playfair_digraph_cipher_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [pcf_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [pcf_pkg::ROW_W-1:0]     cfg_wdata,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          req_type,
    input  wire logic [pcf_pkg::CHAR_W-1:0]    first_char,
    input  wire logic [pcf_pkg::CHAR_W-1:0]    second_char,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pcf_pkg::CHAR_W-1:0]         out_first,
    output logic [pcf_pkg::CHAR_W-1:0]         out_second,
    output logic                               status
);

    pcf_pkg::square_t                  square_reg;

    logic                              s1_valid_reg;
    logic                              s1_type_reg;
    logic [pcf_pkg::CHAR_W-1:0]        s1_first_reg;
    logic [pcf_pkg::CHAR_W-1:0]        s1_second_reg;

    logic                              out_valid_reg;
    logic [pcf_pkg::CHAR_W-1:0]        out_first_reg;
    logic [pcf_pkg::CHAR_W-1:0]        out_second_reg;
    logic                              status_reg;

    logic                              out_adv;
    logic                              in_take;

    pcf_pkg::cell_pos_t                pos_a;
    pcf_pkg::cell_pos_t                pos_b;
    logic                              backward;
    logic [pcf_pkg::CHAR_W-1:0]        out_first_next;
    logic [pcf_pkg::CHAR_W-1:0]        out_second_next;
    logic                              status_next;

    // Square row writes; indexes past the last row are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg <= '0;
        end
        else if (cfg_we && (cfg_addr < pcf_pkg::ADDR_W'(pcf_pkg::SIDE)))
        begin
            square_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Pipeline flow: the result register moves when empty or taken
    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_adv;
    assign in_take  = in_valid && in_ready;

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_type_reg   <= req_type;
            s1_first_reg  <= first_char;
            s1_second_reg <= second_char;
        end
    end

    // Locate both letters and pick the transformed pair
    always_comb
    begin
        pos_a    = pcf_pkg::locate(square_reg, s1_first_reg);
        pos_b    = pcf_pkg::locate(square_reg, s1_second_reg);
        backward = (s1_type_reg == pcf_pkg::REQ_DECRYPT);

        if (!pos_a.found || !pos_b.found)
        begin
            out_first_next  = s1_first_reg;
            out_second_next = s1_second_reg;
            status_next     = pcf_pkg::STATUS_MISSING;
        end
        else if (pos_a.row == pos_b.row)
        begin
            out_first_next  = square_reg[pos_a.row][pcf_pkg::step_pos(pos_a.col, backward)];
            out_second_next = square_reg[pos_a.row][pcf_pkg::step_pos(pos_b.col, backward)];
            status_next     = pcf_pkg::STATUS_OK;
        end
        else if (pos_a.col == pos_b.col)
        begin
            out_first_next  = square_reg[pcf_pkg::step_pos(pos_a.row, backward)][pos_a.col];
            out_second_next = square_reg[pcf_pkg::step_pos(pos_b.row, backward)][pos_a.col];
            status_next     = pcf_pkg::STATUS_OK;
        end
        else
        begin
            out_first_next  = square_reg[pos_a.row][pos_b.col];
            out_second_next = square_reg[pos_b.row][pos_a.col];
            status_next     = pcf_pkg::STATUS_OK;
        end
    end

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pcf_checker.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher port checker
// Watches the core's channels for stall behaviour and pipeline timing.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [pcf_pkg::CHAR_W-1:0] out_first,
    input wire logic [pcf_pkg::CHAR_W-1:0] out_second,
    input wire logic                       status
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Hold the payload of a stalled result
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_first) && $stable(out_second) && $stable(status))
        else $error("result payload changed while stalled");

    // Refuse input only when both stages are full and the output is blocked
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without a blocked result");

    // A fresh result follows an accepted item through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching item");

endmodule

bind playfair_digraph_cipher_core pcf_checker u_pcf_checker (.*);

`default_nettype wire

// ----- tb/tb_playfair_digraph_cipher_core.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher core testbench
// Loads key squares through the configuration port, sends letter pairs for
// encryption and decryption, and checks every returned pair against a typed
// result or a behavioural prediction of the cipher. A directed table covers
// reset values, wrap in both directions, shared cells, repeated codes and
// missing letters. Random phases follow with distinct, crowded and flat
// squares, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_playfair_digraph_cipher_core;

    timeunit 1ns;
    timeprecision 1ps;

    // Shared geometry and codes
    localparam int   SIDE           = pcf_pkg::SIDE;
    localparam int   CHAR_W         = pcf_pkg::CHAR_W;
    localparam int   ROW_W          = pcf_pkg::ROW_W;
    localparam int   ADDR_W         = pcf_pkg::ADDR_W;
    localparam logic REQ_ENCRYPT    = pcf_pkg::REQ_ENCRYPT;
    localparam logic REQ_DECRYPT    = pcf_pkg::REQ_DECRYPT;
    localparam logic STATUS_OK      = pcf_pkg::STATUS_OK;
    localparam logic STATUS_MISSING = pcf_pkg::STATUS_MISSING;

    typedef pcf_pkg::square_t square_t;

    // Register map
    localparam int REG_SQUARE_ROW_0 = 0;
    localparam int REG_FIRST_SPARE  = REG_SQUARE_ROW_0 + SIDE;
    localparam int REG_LAST_SPARE   = (1 << ADDR_W) - 1;

    // Run shape
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int SQUEEZE_PHASE = 2;
    localparam int SQUEEZE_AT    = 10;
    localparam int SQUEEZE_HOLD  = 80;
    localparam int MAX_GAP       = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 1000;

    typedef struct packed {
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
        logic              status;
    } pair_result_t;

    // Which square a directed row runs against
    localparam logic [1:0] KEY_RESET = 2'd0;
    localparam logic [1:0] KEY_ALPHA = 2'd1;
    localparam logic [1:0] KEY_EDGE  = 2'd2;

    localparam logic CHECK_TYPED   = 1'b1;
    localparam logic CHECK_PREDICT = 1'b0;

    typedef struct packed {
        logic [1:0]        key;
        logic              req;
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
        logic              check;
        pair_result_t      want;
    } pair_vector_t;

    typedef enum logic [1:0] {FILL_DISTINCT, FILL_CROWDED, FILL_ZERO, FILL_ONES} fill_t;

    // Rows read right to left, since column 0 sits in the low byte
    localparam square_t ALPHA_SQUARE = {"ZYXWV", "UTSRQ", "PONML", "KIHGF", "EDCBA"};

    // Extreme codes, and 8'h41 both in row 0 and in row 3
    localparam square_t EDGE_SQUARE = {40'hEE_DD_CC_BB_AA, 40'h55_41_33_22_11,
                                       40'h50_40_30_20_10, 40'h05_04_03_02_01,
                                       40'hFF_7F_80_41_00};

    localparam int NUM_VECTORS = 20;
    localparam pair_vector_t DIRECTED_PAIRS [NUM_VECTORS] = '{
        // all-zero square after reset: zero sits in every cell, last one wins
        '{KEY_RESET, REQ_ENCRYPT, 8'h00, 8'h00, CHECK_TYPED, '{8'h00, 8'h00, STATUS_OK}},
        '{KEY_RESET, REQ_DECRYPT, 8'h00, 8'h00, CHECK_TYPED, '{8'h00, 8'h00, STATUS_OK}},
        '{KEY_RESET, REQ_ENCRYPT, 8'hFF, 8'h00, CHECK_TYPED, '{8'hFF, 8'h00, STATUS_MISSING}},
        '{KEY_RESET, REQ_DECRYPT, 8'h00, 8'hFF, CHECK_TYPED, '{8'h00, 8'hFF, STATUS_MISSING}},
        // same row, same column with wrap in both directions
        '{KEY_ALPHA, REQ_ENCRYPT, "A", "E", CHECK_PREDICT, '0},
        '{KEY_ALPHA, REQ_DECRYPT, "A", "E", CHECK_PREDICT, '0},
        '{KEY_ALPHA, REQ_ENCRYPT, "A", "V", CHECK_PREDICT, '0},
        '{KEY_ALPHA, REQ_DECRYPT, "A", "V", CHECK_PREDICT, '0},
        '{KEY_ALPHA, REQ_ENCRYPT, "Z", "K", CHECK_PREDICT, '0},
        // rectangle corners, then a same-column pair
        '{KEY_ALPHA, REQ_ENCRYPT, "A", "G", CHECK_PREDICT, '0},
        '{KEY_ALPHA, REQ_DECRYPT, "H", "S", CHECK_PREDICT, '0},
        // both letters in one cell
        '{KEY_ALPHA, REQ_ENCRYPT, "M", "M", CHECK_PREDICT, '0},
        '{KEY_ALPHA, REQ_DECRYPT, "A", "A", CHECK_PREDICT, '0},
        // missing letters pass through
        '{KEY_ALPHA, REQ_ENCRYPT, "J", "A", CHECK_TYPED, '{"J", "A", STATUS_MISSING}},
        '{KEY_ALPHA, REQ_DECRYPT, "A", "J", CHECK_TYPED, '{"A", "J", STATUS_MISSING}},
        '{KEY_ALPHA, REQ_ENCRYPT, 8'h00, 8'hFF, CHECK_TYPED, '{8'h00, 8'hFF, STATUS_MISSING}},
        // repeated code resolves to the later cell, extremes at the row ends
        '{KEY_EDGE, REQ_ENCRYPT, 8'h41, 8'h22, CHECK_PREDICT, '0},
        '{KEY_EDGE, REQ_ENCRYPT, 8'h00, 8'hFF, CHECK_PREDICT, '0},
        '{KEY_EDGE, REQ_DECRYPT, 8'h00, 8'hFF, CHECK_PREDICT, '0},
        '{KEY_EDGE, REQ_DECRYPT, 8'h00, 8'hAA, CHECK_PREDICT, '0}
    };

    localparam fill_t PHASE_FILLS [NUM_PHASES] = '{
        FILL_DISTINCT, FILL_CROWDED, FILL_DISTINCT, FILL_ZERO,
        FILL_DISTINCT, FILL_CROWDED, FILL_ONES, FILL_DISTINCT
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [ROW_W-1:0]  cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic [CHAR_W-1:0] first_char;
    logic [CHAR_W-1:0] second_char;
    logic              out_valid;
    logic              out_ready;
    logic [CHAR_W-1:0] out_first;
    logic [CHAR_W-1:0] out_second;
    logic              status;

    square_t      key_square;
    pair_result_t pending_pairs [$];
    int           errors;
    int           stalled_cycles;
    int           pairs_returned;
    bit           sender_burst;
    bit           squeeze;
    logic [1:0]   loaded_key;
    logic         rnd_req;
    logic [CHAR_W-1:0] rnd_a;
    logic [CHAR_W-1:0] rnd_b;

    playfair_digraph_cipher_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .first_char  (first_char),
        .second_char (second_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_first   (out_first),
        .out_second  (out_second),
        .status      (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Scan from the last cell back so the first hit is the latest match
    function automatic bit find_cell(input logic [CHAR_W-1:0] code, output int row,
                                     output int col);
        int idx;
        row = 0;
        col = 0;
        for (idx = SIDE * SIDE - 1; idx >= 0; idx--)
        begin
            if (key_square[idx / SIDE][idx % SIDE] == code)
            begin
                row = idx / SIDE;
                col = idx % SIDE;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic pair_result_t cipher_pair(input logic req,
                                                 input logic [CHAR_W-1:0] a,
                                                 input logic [CHAR_W-1:0] b);
        int           ar, ac, br, bc;
        int           delta;
        bit           fa, fb;
        pair_result_t res;
        fa = find_cell(a, ar, ac);
        fb = find_cell(b, br, bc);
        // a step back is SIDE-1 steps forward round the wrap
        delta = (req == REQ_DECRYPT) ? SIDE - 1 : 1;
        if (!(fa && fb))
            res = '{a, b, STATUS_MISSING};
        else if (ar == br)
            res = '{key_square[ar][(ac + delta) % SIDE], key_square[ar][(bc + delta) % SIDE],
                    STATUS_OK};
        else if (ac == bc)
            res = '{key_square[(ar + delta) % SIDE][ac], key_square[(br + delta) % SIDE][bc],
                    STATUS_OK};
        else
            res = '{key_square[ar][bc], key_square[br][ac], STATUS_OK};
        return res;
    endfunction

    function automatic square_t random_square(input fill_t fill);
        square_t           sq;
        bit [255:0]        taken;
        logic [CHAR_W-1:0] code;
        taken = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                case (fill)
                    FILL_DISTINCT:
                    begin
                        code = CHAR_W'($urandom_range(0, 255));
                        while (taken[code])
                            code = CHAR_W'($urandom_range(0, 255));
                        taken[code] = 1'b1;
                    end
                    FILL_CROWDED: code = 8'h60 + CHAR_W'($urandom_range(0, 7));
                    FILL_ZERO:    code = 8'h00;
                    default:      code = 8'hFF;
                endcase
                sq[r][c] = code;
            end
        end
        return sq;
    endfunction

    // Mostly letters from the square, now and then any code
    function automatic logic [CHAR_W-1:0] pick_code();
        if ($urandom_range(0, 9) < 8)
            return key_square[$urandom_range(0, SIDE - 1)][$urandom_range(0, SIDE - 1)];
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Wait for the block to drain, then write every row and one spare index
    task automatic load_square(input square_t sq);
        int               addr;
        logic [ROW_W-1:0] data;
        in_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        for (int i = 0; i <= SIDE; i++)
        begin
            if (i < SIDE)
            begin
                addr = REG_SQUARE_ROW_0 + i;
                data = sq[i];
            end
            else
            begin
                addr = $urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE);
                data = ROW_W'({$urandom(), $urandom()});
            end
            cfg_we    <= 1'b1;
            cfg_addr  <= ADDR_W'(addr);
            cfg_wdata <= data;
            if (addr < REG_FIRST_SPARE)
                key_square[addr - REG_SQUARE_ROW_0] = data;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one pair from a falling edge and hold it until accepted
    task automatic send_pair(input logic req, input logic [CHAR_W-1:0] a,
                             input logic [CHAR_W-1:0] b, input pair_result_t want);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        first_char  <= a;
        second_char <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pairs.push_back(want);
        @(negedge clk);
    endtask

    task automatic report_field(input string what, input logic [CHAR_W-1:0] want,
                                input logic [CHAR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %02h, got %02h", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side: random stalls, runs of steady ready, one long hold-off
    initial
    begin
        int           gap;
        pair_result_t want;
        out_ready = 1'b0;
        pairs_returned = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (squeeze)
            begin
                gap = SQUEEZE_HOLD;
                squeeze = 1'b0;
            end
            else if (pairs_returned % 64 < 16)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            pairs_returned++;
            if (pending_pairs.size() == 0)
            begin
                $display("%0t: unexpected pair %02h %02h status %0b", $time,
                         out_first, out_second, status);
                errors++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                report_field("out_first", want.first, out_first);
                report_field("out_second", want.second, out_second);
                report_field("status", CHAR_W'(want.status), CHAR_W'(status));
            end
            @(negedge clk);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        req_type       = REQ_ENCRYPT;
        first_char     = '0;
        second_char    = '0;
        key_square     = '0;
        errors         = 0;
        stalled_cycles = 0;
        sender_burst   = 1'b0;
        squeeze        = 1'b0;
        loaded_key     = KEY_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            if (DIRECTED_PAIRS[i].key != loaded_key)
            begin
                load_square(DIRECTED_PAIRS[i].key == KEY_ALPHA ? ALPHA_SQUARE : EDGE_SQUARE);
                loaded_key = DIRECTED_PAIRS[i].key;
            end
            send_pair(DIRECTED_PAIRS[i].req, DIRECTED_PAIRS[i].a, DIRECTED_PAIRS[i].b,
                      DIRECTED_PAIRS[i].check == CHECK_TYPED ? DIRECTED_PAIRS[i].want :
                      cipher_pair(DIRECTED_PAIRS[i].req, DIRECTED_PAIRS[i].a,
                                  DIRECTED_PAIRS[i].b));
        end

        // Random phases, a fresh square for each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_square(random_square(PHASE_FILLS[p]));
            sender_burst = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == SQUEEZE_PHASE && n == SQUEEZE_AT)
                    squeeze = 1'b1;
                rnd_req = 1'($urandom_range(0, 1));
                rnd_a   = pick_code();
                rnd_b   = pick_code();
                send_pair(rnd_req, rnd_a, rnd_b, cipher_pair(rnd_req, rnd_a, rnd_b));
            end
        end

        // Drain, then watch for stray results
        in_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(negedge clk);
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
